// ===== hdl/ple_pkg.sv =====
// Shared types and constants for the positional list engine.
// No dependencies; used by the interfaces, cells, top level and checker.
package ple_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OP_W     = 2;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int RDVAL_W  = 32;
  localparam int FPOS_W   = 6;
  localparam int COUNT_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_READ   = 2'd2,
    OP_FIND   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // per-request command broadcast along the cell row
  typedef struct packed {
    logic load;  // request accepted: hit flags update
    logic ins;   // insert that succeeds
    logic ers;   // erase that succeeds
    logic rd;    // read that succeeds
    logic fnd;   // find
  } ple_cmd_t;

endpackage

// ===== hdl/ple_if.sv =====
// Valid/ready channel interfaces for the positional list engine.
// Depends on ple_pkg for field widths.
interface ple_in_if;
  logic                        valid;
  logic                        ready;
  logic [ple_pkg::OP_W-1:0]    operation;
  logic [ple_pkg::POS_W-1:0]   position;
  logic [ple_pkg::VALUE_W-1:0] value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink   (input valid, input operation, input position, input value,
                  output ready);
endinterface

interface ple_out_if;
  logic                         valid;
  logic                         ready;
  logic [ple_pkg::STATUS_W-1:0] status;
  logic [ple_pkg::RDVAL_W-1:0]  read_value;
  logic [ple_pkg::FPOS_W-1:0]   found_position;
  logic [ple_pkg::COUNT_W-1:0]  entry_count;

  modport source (output valid, output status, output read_value,
                  output found_position, output entry_count, input ready);
  modport sink   (input valid, input status, input read_value,
                  input found_position, input entry_count, output ready);
endinterface

// ===== hdl/ple_cell.sv =====
// One list slot: holds an entry, shifts with its neighbors, flags read/find hits.
// Depends on ple_pkg.
module ple_cell #(
  parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF,
  parameter int CMPW       = 8,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  ple_pkg::ple_cmd_t     cmd,
  input  logic [CMPW-1:0]       pos,
  input  logic [CMPW-1:0]       cnt,
  input  logic [DATA_WIDTH-1:0] value,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  hit_o
);

  localparam logic [CMPW-1:0] MY_IDX = CMPW'(IDX);

  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic                  hit_r, hit_nxt;
  logic                  at_pos, after_pos, in_list;

  assign at_pos    = (MY_IDX == pos);
  assign after_pos = (MY_IDX > pos);
  assign in_list   = (MY_IDX < cnt);

  always_comb begin
    data_nxt = data_r;
    if (cmd.ins) begin
      if (at_pos) data_nxt = value;
      else if (after_pos) data_nxt = left_data;
    end else if (cmd.ers) begin
      if (at_pos || after_pos) data_nxt = right_data;
    end
    hit_nxt = (cmd.rd && at_pos) || (cmd.fnd && in_list && (data_r == value));
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (cmd.load) hit_r <= hit_nxt;
  end

  assign data_o = data_r;
  assign hit_o  = hit_r;

endmodule

// ===== hdl/positional_list_engine.sv =====
// Positional list engine: the result of a request is registered, and no new request is
// taken while the previous one is still held in the cells.
// Hit flags in each cell and the output register sit between request and result.
// A stalled result holds the engine; the next request is taken once the flags move on.
// Synchronous active-low reset clears the entry count and handshake state;
// entry contents are undefined until written.
module positional_list_engine #(
  parameter int CAPACITY   = ple_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  ple_in_if.sink           in_chan,
  ple_out_if.source        out_chan
);

  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int CMPW = (CNTW > ple_pkg::POS_W) ? CNTW : ple_pkg::POS_W;
  localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CMPW-1:0] CAP_C = CMPW'(CAPACITY);

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]   cell_hit;

  logic                  accept;
  logic [CMPW-1:0]       pos_e, cnt_e;
  logic [DATA_WIDTH-1:0] value_cut;
  ple_pkg::op_t          op;
  ple_pkg::status_t      in_status;
  ple_pkg::ple_cmd_t     cmd;

  logic [CNTW-1:0]       cnt_r, cnt_nxt;
  logic                  s1_valid_r, s1_valid_nxt;
  ple_pkg::op_t          s1_op_r;
  ple_pkg::status_t      s1_status_r;

  logic                              out_valid_r, out_valid_nxt;
  ple_pkg::status_t                  out_status_r;
  logic [ple_pkg::RDVAL_W-1:0]       out_rdval_r;
  logic [ple_pkg::FPOS_W-1:0]        out_fpos_r;
  logic [ple_pkg::COUNT_W-1:0]       out_count_r;

  logic                  advance;
  logic                  any_hit;
  logic [IW-1:0]         first_hit;
  logic [DATA_WIDTH-1:0] rd_or;
  ple_pkg::status_t      res_status;

  assign in_chan.ready = !s1_valid_r;
  assign accept        = in_chan.valid && !s1_valid_r;
  assign op            = ple_pkg::op_t'(in_chan.operation);
  assign pos_e         = CMPW'(in_chan.position);
  assign cnt_e         = CMPW'(cnt_r);
  assign value_cut     = DATA_WIDTH'(in_chan.value);

  always_comb begin
    in_status = ple_pkg::ST_OK;
    case (op)
      ple_pkg::OP_INSERT: begin
        if (pos_e > cnt_e) in_status = ple_pkg::ST_RANGE;
        else if (cnt_e == CAP_C) in_status = ple_pkg::ST_FULL;
      end
      ple_pkg::OP_ERASE, ple_pkg::OP_READ: begin
        if (pos_e >= cnt_e) in_status = ple_pkg::ST_RANGE;
      end
      default: in_status = ple_pkg::ST_OK;
    endcase
    cmd.load = accept;
    cmd.ins  = accept && (op == ple_pkg::OP_INSERT) && (in_status == ple_pkg::ST_OK);
    cmd.ers  = accept && (op == ple_pkg::OP_ERASE) && (in_status == ple_pkg::ST_OK);
    cmd.rd   = accept && (op == ple_pkg::OP_READ) && (in_status == ple_pkg::ST_OK);
    cmd.fnd  = accept && (op == ple_pkg::OP_FIND);
    cnt_nxt = cnt_r;
    if (cmd.ins) cnt_nxt = cnt_r + CNTW'(1);
    else if (cmd.ers) cnt_nxt = cnt_r - CNTW'(1);
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d, right_d;
    if (g == 0) begin : g_head
      assign left_d = cell_data[g];
    end else begin : g_mid
      assign left_d = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_d = cell_data[g];
    end else begin : g_body
      assign right_d = cell_data[g+1];
    end
    ple_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CMPW       (CMPW),
      .IDX        (g)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .pos        (pos_e),
      .cnt        (cnt_e),
      .value      (value_cut),
      .left_data  (left_d),
      .right_data (right_d),
      .data_o     (cell_data[g]),
      .hit_o      (cell_hit[g])
    );
  end

  // first hit wins for find; at most one hit for read
  always_comb begin
    any_hit   = 1'b0;
    first_hit = '0;
    rd_or     = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (cell_hit[i]) begin
        any_hit   = 1'b1;
        first_hit = IW'(i);
      end
      rd_or = rd_or | (cell_data[i] & {DATA_WIDTH{cell_hit[i]}});
    end
    res_status = s1_status_r;
    if (s1_op_r == ple_pkg::OP_FIND && !any_hit) res_status = ple_pkg::ST_NOT_FOUND;
  end

  assign advance       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign s1_valid_nxt  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = advance ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r     <= op;
      s1_status_r <= in_status;
    end
    if (advance) begin
      out_status_r <= res_status;
      out_rdval_r  <= (s1_op_r == ple_pkg::OP_READ && s1_status_r == ple_pkg::ST_OK)
                      ? ple_pkg::RDVAL_W'(rd_or) : '0;
      out_fpos_r   <= (s1_op_r == ple_pkg::OP_FIND && any_hit)
                      ? ple_pkg::FPOS_W'(first_hit) : '0;
      out_count_r  <= ple_pkg::COUNT_W'(cnt_r);
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = out_status_r;
  assign out_chan.read_value     = out_rdval_r;
  assign out_chan.found_position = out_fpos_r;
  assign out_chan.entry_count    = out_count_r;

endmodule

// ===== hdl/ple_checker.sv =====
// Port-level checks for the positional list engine, bound to the top level.
// Depends on ple_pkg and positional_list_engine.
module ple_checker #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ple_pkg::STATUS_W-1:0] status,
  input logic [ple_pkg::RDVAL_W-1:0]  read_value,
  input logic [ple_pkg::FPOS_W-1:0]   found_position,
  input logic [ple_pkg::COUNT_W-1:0]  entry_count
);

  localparam logic [ple_pkg::COUNT_W-1:0] CAP_C = ple_pkg::COUNT_W'(CAPACITY);

  // one request in flight in the cell row
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while previous still in cells");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CAPACITY > 127 || entry_count <= CAP_C))
    else $error("entry count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status == ple_pkg::ST_FULL) |-> entry_count == CAP_C)
    else $error("full status with list not full");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status == ple_pkg::ST_NOT_FOUND) |->
      (found_position == '0 && read_value == '0))
    else $error("not-found result carries data");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) &&
      $stable(read_value) && $stable(found_position) && $stable(entry_count)))
    else $error("stalled result changed");

endmodule

bind positional_list_engine ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .status         (out_chan.status),
  .read_value     (out_chan.read_value),
  .found_position (out_chan.found_position),
  .entry_count    (out_chan.entry_count)
);

// ===== verif/ple_list_checker.sv =====
// Scoreboard for the positional list engine: keeps a shadow list, predicts each result
// and compares it field by field with what comes out of the result channel.
// Depends on ple_pkg and the channel interfaces in ple_if.sv.
module ple_list_checker (
  input  logic        clk,
  input  logic        rst_n,
  ple_in_if           in_mon,
  ple_out_if          out_mon,
  output int unsigned fail_count,
  output int unsigned awaiting,
  output int unsigned list_len,
  output int unsigned checked_total,
  output int unsigned full_total,
  output int unsigned miss_total
);

  typedef struct packed {
    ple_pkg::status_t              status;
    logic [ple_pkg::RDVAL_W-1:0]   read_value;
    logic [ple_pkg::FPOS_W-1:0]    found_position;
    logic [ple_pkg::COUNT_W-1:0]   entry_count;
  } list_result_t;

  logic [ple_pkg::VALUE_W-1:0] shadow_list [ple_pkg::CAPACITY_DEF];
  list_result_t                result_q [$];

  function automatic list_result_t apply_request(ple_pkg::op_t op,
                                                 logic [ple_pkg::POS_W-1:0] pos,
                                                 logic [ple_pkg::VALUE_W-1:0] val);
    list_result_t r;
    int           idx;
    r = '0;
    r.status = ple_pkg::ST_OK;
    case (op)
      ple_pkg::OP_INSERT: begin
        if (pos > list_len) begin
          r.status = ple_pkg::ST_RANGE;
        end else if (list_len >= ple_pkg::CAPACITY_DEF) begin
          r.status = ple_pkg::ST_FULL;
        end else begin
          for (idx = list_len; idx > pos; idx--) shadow_list[idx] = shadow_list[idx-1];
          shadow_list[pos] = val;
          list_len++;
        end
      end
      ple_pkg::OP_ERASE: begin
        if (pos >= list_len) begin
          r.status = ple_pkg::ST_RANGE;
        end else begin
          for (idx = pos; idx + 1 < list_len; idx++) shadow_list[idx] = shadow_list[idx+1];
          list_len--;
        end
      end
      ple_pkg::OP_READ: begin
        if (pos >= list_len) r.status = ple_pkg::ST_RANGE;
        else r.read_value = shadow_list[pos];
      end
      ple_pkg::OP_FIND: begin
        r.status = ple_pkg::ST_NOT_FOUND;
        for (idx = 0; idx < list_len; idx++) begin
          if (shadow_list[idx] == val) begin
            r.status = ple_pkg::ST_OK;
            r.found_position = idx[ple_pkg::FPOS_W-1:0];
            break;
          end
        end
      end
      default: ;
    endcase
    r.entry_count = list_len[ple_pkg::COUNT_W-1:0];
    return r;
  endfunction

  task automatic report_error(string what, logic [31:0] want, logic [31:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      result_q.delete();
      list_len      = 0;
      fail_count    = 0;
      checked_total = 0;
      full_total    = 0;
      miss_total    = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (result_q.size() == 0) begin
          report_error("unexpected result, status", '0, 32'(out_mon.status));
        end else begin
          want = result_q[0];
          result_q.delete(0);
          checked_total++;
          if (want.status == ple_pkg::ST_FULL) full_total++;
          if (want.status == ple_pkg::ST_NOT_FOUND) miss_total++;
          if (out_mon.status !== want.status)
            report_error("status", 32'(want.status), 32'(out_mon.status));
          if (out_mon.read_value !== want.read_value)
            report_error("read_value", want.read_value, out_mon.read_value);
          if (out_mon.found_position !== want.found_position)
            report_error("found_position", 32'(want.found_position),
                         32'(out_mon.found_position));
          if (out_mon.entry_count !== want.entry_count)
            report_error("entry_count", 32'(want.entry_count), 32'(out_mon.entry_count));
        end
      end
      if (in_mon.valid && in_mon.ready)
        result_q.push_back(apply_request(ple_pkg::op_t'(in_mon.operation), in_mon.position,
                                         in_mon.value));
    end
    awaiting = result_q.size();
  end

endmodule

// ===== verif/tb_positional_list_engine.sv =====
// Top of the positional list engine testbench: clock, reset, request and ready stimulus.
// Directed corner requests, then grow / shrink / mixed random phases; ple_list_checker
// does the prediction. Depends on ple_pkg, ple_if.sv and the engine RTL.
module tb_positional_list_engine;

  typedef enum {PHASE_GROW, PHASE_MIXED, PHASE_SHRINK} phase_t;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  bit          calm  = 1'b0;
  int unsigned sent_total = 0;
  int unsigned fail_count, awaiting, list_len, checked_total, full_total, miss_total;

  ple_in_if  in_ch ();
  ple_out_if out_ch ();

  positional_list_engine u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  ple_list_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .awaiting      (awaiting),
    .list_len      (list_len),
    .checked_total (checked_total),
    .full_total    (full_total),
    .miss_total    (miss_total)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 9);
  end

  // small pool so that finds hit and duplicates show up
  function automatic logic [ple_pkg::VALUE_W-1:0] pick_value();
    if ($urandom_range(1) == 0) return $urandom();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      default: return $urandom_range(7);
    endcase
  endfunction

  task automatic send_request(ple_pkg::op_t op, logic [ple_pkg::POS_W-1:0] pos,
                              logic [ple_pkg::VALUE_W-1:0] val);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.position  <= pos;
    in_ch.value     <= val;
    do @(posedge clk); while (!in_ch.ready);
    sent_total++;
  endtask

  task automatic random_request(phase_t phase);
    int unsigned               roll;
    int unsigned               len;
    ple_pkg::op_t              op;
    logic [ple_pkg::POS_W-1:0] pos;
    roll = $urandom_range(99);
    len  = list_len;
    case (phase)
      PHASE_GROW:   op = roll < 85 ? ple_pkg::OP_INSERT : roll < 88 ? ple_pkg::OP_ERASE :
                         roll < 94 ? ple_pkg::OP_READ : ple_pkg::OP_FIND;
      PHASE_SHRINK: op = roll < 6 ? ple_pkg::OP_INSERT : roll < 86 ? ple_pkg::OP_ERASE :
                         roll < 93 ? ple_pkg::OP_READ : ple_pkg::OP_FIND;
      default:      op = roll < 35 ? ple_pkg::OP_INSERT : roll < 65 ? ple_pkg::OP_ERASE :
                         roll < 83 ? ple_pkg::OP_READ : ple_pkg::OP_FIND;
    endcase
    if ($urandom_range(99) < 8 || op == ple_pkg::OP_FIND)
      pos = ple_pkg::POS_W'($urandom_range(127));
    else if (op == ple_pkg::OP_INSERT)
      pos = ple_pkg::POS_W'($urandom_range(len));
    else
      pos = len == 0 ? '0 : ple_pkg::POS_W'($urandom_range(len - 1));
    send_request(op, pos, pick_value());
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.operation = ple_pkg::OP_INSERT;
    in_ch.position  = '0;
    in_ch.value     = '0;
    out_ch.ready    = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // empty list, beyond-end insert
    send_request(ple_pkg::OP_READ, 7'd0, '0);
    send_request(ple_pkg::OP_ERASE, 7'd0, '0);
    send_request(ple_pkg::OP_FIND, 7'd0, '0);
    send_request(ple_pkg::OP_INSERT, 7'd1, 32'h1);
    send_request(ple_pkg::OP_INSERT, 7'd127, '1);
    // build a short list with a duplicate
    send_request(ple_pkg::OP_INSERT, 7'd0, '0);
    send_request(ple_pkg::OP_INSERT, 7'd1, '1);
    send_request(ple_pkg::OP_INSERT, 7'd0, 32'hA5A5_A5A5);
    send_request(ple_pkg::OP_INSERT, 7'd3, 32'h5A5A_5A5A);
    send_request(ple_pkg::OP_INSERT, 7'd2, '1);
    send_request(ple_pkg::OP_READ, 7'd0, '0);
    send_request(ple_pkg::OP_READ, 7'd1, '0);
    send_request(ple_pkg::OP_READ, 7'd2, '0);
    send_request(ple_pkg::OP_READ, 7'd4, '0);
    send_request(ple_pkg::OP_READ, 7'd5, '0);
    send_request(ple_pkg::OP_READ, 7'd127, '0);
    send_request(ple_pkg::OP_FIND, 7'd0, '1);
    send_request(ple_pkg::OP_FIND, 7'd127, 32'h1234_5678);
    send_request(ple_pkg::OP_FIND, 7'd0, '0);
    send_request(ple_pkg::OP_ERASE, 7'd127, '0);
    send_request(ple_pkg::OP_ERASE, 7'd5, '0);
    send_request(ple_pkg::OP_ERASE, 7'd2, '0);
    send_request(ple_pkg::OP_ERASE, 7'd3, '0);
    send_request(ple_pkg::OP_ERASE, 7'd0, '0);
    send_request(ple_pkg::OP_READ, 7'd0, '0);

    for (int seg = 0; seg < 12; seg++) begin
      calm = (seg == 5);
      repeat (150) begin
        case (seg % 4)
          0:       random_request(PHASE_GROW);
          2:       random_request(PHASE_SHRINK);
          default: random_request(PHASE_MIXED);
        endcase
      end
    end
    calm = 1'b0;

    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (awaiting == 0);
    repeat (10) @(posedge clk);
    $display("Summary: %0d requests sent, %0d results checked", sent_total, checked_total);
    $display("  (%0d full rejections, %0d failed finds)", full_total, miss_total);
    if (fail_count == 0 && awaiting == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Timeout with %0d results outstanding", awaiting);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
